// File: hdl/mric_pkg.sv
// Shared types and constants for the minimum-rotation inversion counter.
// Used by mric_fenwick and min_rotation_inversion_count; no dependencies.
package mric_pkg;

  localparam int LABEL_W  = 11;
  localparam int LEN_W    = 11;
  localparam int RESULT_W = 19;
  // Signed width of the running inversion total, wide enough for any
  // shift pass at the largest length the 11-bit register allows.
  localparam int TOTAL_W  = 25;

  localparam logic [LEN_W-1:0] SEQ_LENGTH_RESET = 11'd1024;
  localparam logic signed [TOTAL_W-1:0] OUT_MAX = 25'sd524287;

  typedef struct packed {
    logic               mode;
    logic [LABEL_W-1:0] label;
  } in_item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] min_inversions;
    logic                bad_input;
  } result_t;

  typedef enum logic [1:0] {
    FW_CLEAR = 2'd0,
    FW_QUERY = 2'd1,
    FW_BUMP  = 2'd2
  } fw_op_t;

  typedef struct packed {
    logic   go;
    fw_op_t op;
  } fw_req_t;

endpackage

// File: hdl/mric_fenwick.sv
// Fenwick prefix-count store with its own walker: clear sweep, prefix
// query and point bump, one memory step at a time. Depends on mric_pkg.
module mric_fenwick import mric_pkg::*; #(
  parameter int MAX_LENGTH = 1024,
  localparam int AW = $clog2(MAX_LENGTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  fw_req_t       req,
  input  logic [AW-1:0] idx,
  output logic          done,
  output logic [AW-1:0] sum
);

  localparam int XW = AW + 1;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_CLR  = 6'b000010,
    F_QRD  = 6'b000100,
    F_QACC = 6'b001000,
    F_BRD  = 6'b010000,
    F_BWR  = 6'b100000
  } fstate_t;

  fstate_t       state, state_next;
  logic [XW-1:0] x, x_next;
  logic [AW-1:0] sum_next;
  logic          done_next;
  logic [XW-1:0] low_bit;
  logic [AW-1:0] fen [0:MAX_LENGTH];
  logic [AW-1:0] rdata;
  logic          we;
  logic [AW-1:0] wdata;

  assign low_bit = x & (~x + XW'(1));

  always_comb begin
    state_next = state;
    x_next     = x;
    sum_next   = sum;
    done_next  = 1'b0;
    we         = 1'b0;
    wdata      = rdata + AW'(1);
    unique case (state)
      F_IDLE: begin
        if (req.go) begin
          case (req.op)
            FW_CLEAR: begin
              x_next     = '0;
              state_next = F_CLR;
            end
            FW_QUERY: begin
              x_next     = XW'(idx);
              sum_next   = '0;
              state_next = F_QRD;
            end
            FW_BUMP: begin
              x_next     = XW'(idx);
              state_next = F_BRD;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      F_CLR: begin
        we    = 1'b1;
        wdata = '0;
        if (x == XW'(MAX_LENGTH)) begin
          done_next  = 1'b1;
          state_next = F_IDLE;
        end else begin
          x_next = x + XW'(1);
        end
      end
      F_QRD: state_next = F_QACC;
      F_QACC: begin
        sum_next = sum + rdata;
        // strip the lowest set bit to step to the preceding range
        x_next   = x - low_bit;
        if (x_next == '0) begin
          done_next  = 1'b1;
          state_next = F_IDLE;
        end else begin
          state_next = F_QRD;
        end
      end
      F_BRD: state_next = F_BWR;
      F_BWR: begin
        we     = 1'b1;
        x_next = x + low_bit;
        if (x_next > XW'(MAX_LENGTH)) begin
          done_next  = 1'b1;
          state_next = F_IDLE;
        end else begin
          state_next = F_BRD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fen[x[AW-1:0]] <= wdata;
    end
    rdata <= fen[x[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    x   <= x_next;
    sum <= sum_next;
  end

endmodule

// File: hdl/min_rotation_inversion_count.sv
// Minimum inversion count over all cyclic shifts of a second ordering.
// Top level: sequencer, label and mapped-sequence memories; uses mric_pkg
// and mric_fenwick.
//
// A job is seq_length reference labels (mode 0) followed by seq_length
// second-ordering labels (mode 1); one word leaves on result, marked by a
// one-cycle done pulse, after the last mode-1 label. The receiver cannot
// hold it off. A mode-0 label is taken without busy going high. A mode-1
// label walks q Fenwick query steps (set bits of the mapped position) and
// b bump steps (up to log2(MAX_LENGTH)+1), every step a read then an
// accumulate or write on the single port of the Fenwick store. The first
// mode-1 label of a job first sweeps the Fenwick store clear. The last one
// adds a shift pass through the mapped-sequence memory: a set-up step, a
// read then an accumulate for each slot but the last, and an emit step.
// busy is high for the whole of that work.
module min_rotation_inversion_count import mric_pkg::*; #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  in_item_t         item,
  output logic             busy,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  output logic             done,
  output result_t          result
);

  localparam int AW = $clog2(MAX_LENGTH + 1);
  localparam int CW = (AW > LABEL_W) ? AW : LABEL_W;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLR    = 11'b00000000010,
    S_ENTRY  = 11'b00000000100,
    S_LOOKUP = 11'b00000001000,
    S_QUERY  = 11'b00000010000,
    S_BUMP   = 11'b00000100000,
    S_STORE  = 11'b00001000000,
    S_PASS0  = 11'b00010000000,
    S_SHRD   = 11'b00100000000,
    S_SHACC  = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    PH_REF    = 3'b001,
    PH_SECOND = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  state_t                     state;
  phase_t                     phase;
  logic [LEN_W-1:0]           seq_length;
  logic [AW-1:0]              counter;
  logic [AW-1:0]              inserted;
  logic [AW-1:0]              vval;
  logic [AW-1:0]              shidx;
  logic [CW-1:0]              lbl;
  logic                       error_seen;
  logic signed [TOTAL_W-1:0]  running;
  logic signed [TOTAL_W-1:0]  best;

  logic [CW-1:0]              sl_w, n_w, in_label_w;
  logic [AW-1:0]              n;
  logic                       accept, new_job, in_ok, lbl_ok, p_ok;
  logic [AW-1:0]              counter_inc;
  logic [AW-1:0]              shidx_inc;
  logic signed [TOTAL_W-1:0]  delta, total_new, clamped;

  logic [AW-1:0]              label_position [0:MAX_LENGTH];
  logic [AW-1:0]              mapped_sequence [0:MAX_LENGTH];
  logic [AW-1:0]              lp_rdata, ms_rdata;
  logic                       lp_we, ms_we;

  fw_req_t                    fw_req;
  logic [AW-1:0]              fw_idx;
  logic                       fw_done;
  logic [AW-1:0]              fw_sum;

  // effective length: seq_length clamped to 1..MAX_LENGTH
  always_comb begin
    sl_w = CW'(seq_length);
    if (sl_w == '0) begin
      n_w = CW'(1);
    end else if (sl_w > CW'(MAX_LENGTH)) begin
      n_w = CW'(MAX_LENGTH);
    end else begin
      n_w = sl_w;
    end
    n = n_w[AW-1:0];
  end

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign in_label_w  = CW'(item.label);
  assign in_ok       = (in_label_w != '0) && (in_label_w <= n_w);
  assign lbl_ok      = (lbl != '0) && (lbl <= n_w);
  assign p_ok        = (lp_rdata != '0) && (lp_rdata <= n);
  assign new_job     = (phase != PH_REF) || (counter >= n);
  assign counter_inc = (new_job ? AW'(0) : counter) + AW'(1);
  assign shidx_inc   = shidx + AW'(1);

  // moving front value v to the back changes the total by n+1-2v
  assign delta     = TOTAL_W'(n) + TOTAL_W'(1) - (TOTAL_W'(ms_rdata) << 1);
  assign total_new = running + delta;

  always_comb begin
    if (best < 0) begin
      clamped = '0;
    end else if (best > OUT_MAX) begin
      clamped = OUT_MAX;
    end else begin
      clamped = best;
    end
  end

  assign lp_we = accept && !item.mode && in_ok;
  assign ms_we = (state == S_STORE);

  always_ff @(posedge clk) begin
    if (lp_we) begin
      label_position[in_label_w[AW-1:0]] <= counter_inc;
    end
    lp_rdata <= label_position[lbl[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ms_we) begin
      mapped_sequence[counter] <= vval;
    end
    ms_rdata <= mapped_sequence[shidx];
  end

  always_comb begin
    fw_req.go = 1'b0;
    fw_req.op = FW_CLEAR;
    fw_idx    = vval;
    unique case (state)
      S_IDLE: begin
        if (accept && item.mode && phase == PH_REF) begin
          fw_req.go = 1'b1;
        end
      end
      S_LOOKUP: begin
        fw_idx    = lp_rdata;
        fw_req.op = FW_QUERY;
        fw_req.go = p_ok;
      end
      S_QUERY: begin
        fw_req.op = FW_BUMP;
        fw_req.go = fw_done;
      end
      S_CLR, S_ENTRY, S_BUMP, S_STORE, S_PASS0, S_SHRD, S_SHACC, S_EMIT: ;
    endcase
  end

  mric_fenwick #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_fenwick (
    .clk  (clk),
    .rst  (rst),
    .req  (fw_req),
    .idx  (fw_idx),
    .done (fw_done),
    .sum  (fw_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_REF;
      seq_length <= SEQ_LENGTH_RESET;
      counter    <= '0;
      error_seen <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        seq_length <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lbl <= in_label_w;
            if (!item.mode) begin
              phase   <= PH_REF;
              counter <= counter_inc;
              if (new_job) begin
                error_seen <= !in_ok;
              end else if (!in_ok) begin
                error_seen <= 1'b1;
              end
            end else if (phase == PH_REF) begin
              phase    <= PH_SECOND;
              counter  <= '0;
              inserted <= '0;
              running  <= '0;
              state    <= S_CLR;
            end else if (phase == PH_SECOND) begin
              state <= S_ENTRY;
            end
          end
        end
        S_CLR: begin
          if (fw_done) begin
            state <= S_ENTRY;
          end
        end
        S_ENTRY: begin
          if (counter < n) begin
            counter <= counter + AW'(1);
            if (lbl_ok) begin
              state <= S_LOOKUP;
            end else begin
              error_seen <= 1'b1;
              vval       <= '0;
              state      <= S_STORE;
            end
          end else begin
            // length shrank mid-job: finish with the slots taken
            state <= S_PASS0;
          end
        end
        S_LOOKUP: begin
          if (p_ok) begin
            vval  <= lp_rdata;
            state <= S_QUERY;
          end else begin
            error_seen <= 1'b1;
            vval       <= '0;
            state      <= S_STORE;
          end
        end
        S_QUERY: begin
          if (fw_done) begin
            running <= running + TOTAL_W'(inserted) - TOTAL_W'(fw_sum);
            state   <= S_BUMP;
          end
        end
        S_BUMP: begin
          if (fw_done) begin
            inserted <= inserted + AW'(1);
            state    <= S_STORE;
          end
        end
        S_STORE: begin
          state <= (counter < n) ? S_IDLE : S_PASS0;
        end
        S_PASS0: begin
          best  <= running;
          shidx <= AW'(1);
          state <= (counter > AW'(1)) ? S_SHRD : S_EMIT;
        end
        S_SHRD: state <= S_SHACC;
        S_SHACC: begin
          // skip rejected slots
          if (ms_rdata != '0) begin
            running <= total_new;
            if (total_new < best) begin
              best <= total_new;
            end
          end
          shidx <= shidx_inc;
          state <= (shidx_inc < counter) ? S_SHRD : S_EMIT;
        end
        S_EMIT: begin
          phase                 <= PH_DONE;
          done                  <= 1'b1;
          result.min_inversions <= clamped[RESULT_W-1:0];
          result.bad_input      <= error_seen;
          state                 <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/tb_min_rotation_inversion_count.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_rotation_inversion_count: a directed table then random jobs,
// each result word checked against its typed table entry or an in-bench model. Depends on mric_pkg and the block.
module tb_min_rotation_inversion_count;
  import mric_pkg::*;

  localparam int MAX_LEN        = 1024;
  localparam int RANDOM_WORDS   = 1100;
  localparam int SETTLE_CYCLES  = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int IDLE_PCT [3]   = '{0, 47, 17};

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
  typedef enum logic [1:0] {PH_REFERENCE, PH_SECOND, PH_DONE} job_phase_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        mode;
    logic [10:0] value;   // label, or seq_length for a config row
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [28] = '{
    '{ROW_CFG,  1'b0, 11'd1,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd0,    1'b1, '{19'd0, 1'b1}},  // second ordering right after reset
    '{ROW_ITEM, 1'b1, 11'd2047, 1'b0, '0},              // ignored, job complete
    '{ROW_ITEM, 1'b0, 11'd1,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd1,    1'b1, '{19'd0, 1'b0}},
    '{ROW_CFG,  1'b0, 11'd0,    1'b0, '0},              // clamps to a length of one
    '{ROW_ITEM, 1'b0, 11'd2047, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd1,    1'b0, '0},              // reference full: new job
    '{ROW_ITEM, 1'b1, 11'd1,    1'b1, '{19'd0, 1'b0}},
    '{ROW_CFG,  1'b0, 11'd4,    1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd4,    1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd3,    1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd2,    1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd1,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd4,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd3,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd2,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd1,    1'b1, '{19'd0, 1'b0}},  // sorted order, no inversions
    '{ROW_CFG,  1'b0, 11'd2047, 1'b0, '0},              // clamps to MAX_LEN
    '{ROW_ITEM, 1'b0, 11'd1024, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd0,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd1024, 1'b0, '0},              // reference left incomplete
    '{ROW_ITEM, 1'b1, 11'd1,    1'b0, '0},
    '{ROW_CFG,  1'b0, 11'd2,    1'b0, '0},              // shrink to the slots taken
    '{ROW_ITEM, 1'b1, 11'd2047, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 11'd2,    1'b0, '0},
    '{ROW_ITEM, 1'b1, 11'd1,    1'b0, '0},              // position beyond the length
    '{ROW_ITEM, 1'b1, 11'd2,    1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        start;
  in_item_t    item;
  logic        busy;
  logic        cfg_we;
  logic [10:0] cfg_data;
  logic        done;
  result_t     result;

  min_rotation_inversion_count DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Model state
  logic [10:0]  seq_len_reg;
  int unsigned  pos_of_label [0:MAX_LEN];
  bit           pos_written  [0:MAX_LEN];
  int unsigned  mapped_slot  [0:MAX_LEN];
  int unsigned  fen_count    [0:MAX_LEN];
  int unsigned  slots_taken;
  int unsigned  placed;
  longint       run_total;
  longint       best_total;
  bit           err_seen;
  job_phase_t   job_phase;

  result_t min_inv_expected [$];
  int      mismatches;
  int      words_sent;
  int      sender_idle_pct;
  int      idle_cycles;

  function automatic int unsigned eff_len();
    if (seq_len_reg == 0) return 1;
    if (seq_len_reg > MAX_LEN) return MAX_LEN;
    return seq_len_reg;
  endfunction

  function automatic int unsigned fen_prefix(input int unsigned x);
    int unsigned s;
    s = 0;
    while (x != 0) begin
      s += fen_count[x];
      x -= x & (~x + 1);
    end
    return s;
  endfunction

  function automatic void fen_bump(input int unsigned x);
    while (x != 0 && x <= MAX_LEN) begin
      fen_count[x] += 1;
      x += x & (~x + 1);
    end
  endfunction

  function automatic void predict_min_rotation(input in_item_t w, output bit emits,
                                               output result_t r);
    int unsigned n, lbl, p, v, i;
    longint tot;
    n = eff_len();
    lbl = w.label;
    emits = 1'b0;
    r = '0;
    if (w.mode == 1'b0) begin
      if (job_phase != PH_REFERENCE || slots_taken >= n) begin
        job_phase = PH_REFERENCE;
        slots_taken = 0;
        err_seen = 1'b0;
      end
      slots_taken++;
      if (lbl >= 1 && lbl <= n) begin
        pos_of_label[lbl] = slots_taken;
        pos_written[lbl] = 1'b1;
      end else begin
        err_seen = 1'b1;
      end
      return;
    end
    if (job_phase == PH_DONE) return;
    if (job_phase == PH_REFERENCE) begin
      job_phase = PH_SECOND;
      slots_taken = 0;
      for (i = 0; i <= MAX_LEN; i++) fen_count[i] = 0;
      placed = 0;
      run_total = 0;
    end
    if (slots_taken < n) begin
      v = 0;
      slots_taken++;
      if (lbl >= 1 && lbl <= n) begin
        p = pos_of_label[lbl];
        if (p >= 1 && p <= n) v = p;
        else err_seen = 1'b1;
      end else begin
        err_seen = 1'b1;
      end
      if (v != 0) begin
        run_total += longint'(placed) - longint'(fen_prefix(v));
        fen_bump(v);
        placed++;
      end
      mapped_slot[slots_taken] = v;
    end
    if (slots_taken < n) return;
    // rotate: moving front value v to the back shifts the total by n+1-2v
    tot = run_total;
    best_total = tot;
    for (i = 1; i < slots_taken; i++) begin
      if (mapped_slot[i] == 0) continue;
      tot += longint'(n) + 1 - 2 * longint'(mapped_slot[i]);
      if (tot < best_total) best_total = tot;
    end
    run_total = tot;
    job_phase = PH_DONE;
    if (best_total < 0) best_total = 0;
    if (best_total > longint'(OUT_MAX)) best_total = longint'(OUT_MAX);
    r.min_inversions = best_total[RESULT_W-1:0];
    r.bad_input = err_seen;
    emits = 1'b1;
  endfunction

  // Drop second-ordering labels whose position entry was never written.
  function automatic logic [10:0] usable_label(input logic [10:0] lbl);
    if (lbl >= 1 && lbl <= eff_len() && !pos_written[lbl]) return '0;
    return lbl;
  endfunction

  function automatic void make_perm(input int n, ref int q[$]);
    int i, j, t;
    q = {};
    for (i = 1; i <= n; i++) q.push_back(i);
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = q[i];
      q[i] = q[j];
      q[j] = t;
    end
  endfunction

  task automatic send_item(input logic mode, input logic [10:0] lbl,
                           input bit typed = 1'b0, input result_t want = '0);
    in_item_t w;
    bit emits;
    result_t predicted;
    w.mode = mode;
    w.label = lbl;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predict_min_rotation(w, emits, predicted);
    if (emits) min_inv_expected.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Hold start low until the block has drained and gone quiet.
  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    while (min_inv_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
  endtask

  task automatic write_seq_length(input logic [10:0] value);
    settle_block();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    seq_len_reg = value;
  endtask

  task automatic run_job();
    int r, cfgv, n, m, k, split, i, style;
    int ref_order[$], second[$], picks[$];
    logic [10:0] lbl;
    bit shrink, ref_clean;
    r = $urandom_range(99);
    if (r < 5) begin
      // full length, but close the job early by shrinking the length
      write_seq_length(($urandom_range(1) == 0) ? 11'd1024 : 11'd2047);
      m = $urandom_range(4, 24);
      picks = {};
      repeat (m) begin
        lbl = ($urandom_range(3) == 0) ? 11'd1024 : 11'($urandom_range(1, 1024));
        picks.push_back(lbl);
        send_item(1'b0, lbl);
      end
      repeat (m) begin
        lbl = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                       : 11'(picks[$urandom_range(m - 1)]);
        send_item(1'b1, usable_label(lbl));
      end
      write_seq_length(11'($urandom_range(1, m)));
      send_item(1'b1, 11'($urandom_range(2047)));
      return;
    end
    if (r < 12) cfgv = $urandom_range(1);
    else if (r < 80) cfgv = $urandom_range(2, 10);
    else cfgv = $urandom_range(11, 40);
    write_seq_length(11'(cfgv));
    n = eff_len();

    ref_clean = ($urandom_range(99) < 80);
    ref_order = {};
    if (ref_clean) begin
      make_perm(n, ref_order);
      for (i = 0; i < n; i++) send_item(1'b0, 11'(ref_order[i]));
    end else begin
      k = $urandom_range(1, n + 2);
      repeat (k) send_item(1'b0, ($urandom_range(1) == 0) ? 11'($urandom_range(2047))
                                                        : 11'($urandom_range(1, n)));
    end

    style = $urandom_range(99);
    second = {};
    if (ref_clean && style < 15) begin
      for (i = n - 1; i >= 0; i--) second.push_back(ref_order[i]);
    end else if (ref_clean && style < 30) begin
      second = ref_order;
    end else if (style < 80) begin
      make_perm(n, second);
    end else begin
      for (i = 0; i < n; i++) begin
        k = $urandom_range(9);
        if (k < 6) second.push_back($urandom_range(1, n));
        else if (k < 8 || i == 0) second.push_back($urandom_range(2047));
        else second.push_back(second[i - 1]);
      end
    end

    shrink = (n >= 2) && ($urandom_range(9) == 0);
    split = shrink ? $urandom_range(1, n - 1) : n;
    for (i = 0; i < split; i++) send_item(1'b1, usable_label(11'(second[i])));
    if (shrink) begin
      write_seq_length(11'($urandom_range(1, split)));
      send_item(1'b1, 11'($urandom_range(2047)));
    end
    // stray second-ordering word after completion: no result
    if ($urandom_range(9) == 0) send_item(1'b1, 11'($urandom_range(2047)));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (min_inv_expected.size() == 0) begin
        $error("unexpected result word: min_inversions %0d bad_input %0d",
               result.min_inversions, result.bad_input);
        mismatches++;
      end else begin
        want = min_inv_expected.pop_front();
        if (result.min_inversions !== want.min_inversions) begin
          $error("min_inversions: expected %0d, got %0d",
                 want.min_inversions, result.min_inversions);
          mismatches++;
        end
        if (result.bad_input !== want.bad_input) begin
          $error("bad_input: expected %0d, got %0d", want.bad_input, result.bad_input);
          mismatches++;
        end
      end
    end
  end

  // Stop the run if no word moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[min_rotation_inversion_count] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int i, job_idx;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    words_sent = 0;
    idle_cycles = 0;
    sender_idle_pct = 0;
    seq_len_reg = SEQ_LENGTH_RESET;
    for (i = 0; i <= MAX_LEN; i++) begin
      pos_of_label[i] = 0;
      pos_written[i] = 1'b0;
      mapped_slot[i] = 0;
      fen_count[i] = 0;
    end
    slots_taken = 0;
    placed = 0;
    run_total = 0;
    best_total = 0;
    err_seen = 1'b0;
    job_phase = PH_REFERENCE;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_CFG) write_seq_length(DIRECTED[i].value);
      else send_item(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
    end

    words_sent = 0;
    job_idx = 0;
    while (words_sent < RANDOM_WORDS) begin
      sender_idle_pct = IDLE_PCT[job_idx % 3];
      run_job();
      job_idx++;
    end

    settle_block();
    if (mismatches == 0) begin
      $display("[min_rotation_inversion_count] OK");
    end else begin
      $display("[min_rotation_inversion_count] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mric_pkg.sv
hdl/mric_fenwick.sv
hdl/min_rotation_inversion_count.sv
test/tb_min_rotation_inversion_count.sv
